>>> rtl/tcprit_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcprit_pkg
// Shared types and constants for the TCP reassembly interval tracker.
// ---------------------------------------------------------------------------
package tcprit_pkg;

    localparam int SLOTS       = 16;
    localparam int BUF_BYTES   = 2048;
    localparam int IDXW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW          = 17;          // stored offset width
    localparam int VW          = 18;          // working offset width
    localparam int CW          = 13;          // contiguous end width
    localparam int LAST_BYTE   = BUF_BYTES - 1;
    localparam logic [8:0] DRAIN_MAX_RESET = 9'd21;

    localparam logic [2:0] ST_IN_ORDER = 3'd0;
    localparam logic [2:0] ST_STORED   = 3'd1;
    localparam logic [2:0] ST_OLD      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DRAINED  = 3'd4;

    localparam logic [1:0] FIN_NONE    = 2'd0;
    localparam logic [1:0] FIN_PENDING = 2'd1;
    localparam logic [1:0] FIN_DONE    = 2'd2;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] seg_offset;
        logic [10:0]       seg_len;
        logic [11:0]       window_room;
        logic              fin_flag;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [11:0] contiguous_end;
        logic [8:0]        delivered;
        logic              fin_reached;
        logic              trimmed;
    } result_word_t;

    typedef struct packed {
        logic                used;
        logic signed [SW-1:0] first;
        logic signed [SW-1:0] last;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_MERGE,
        S_DECIDE,
        S_STORE,
        S_DRAIN
    } state_t;

endpackage
`default_nettype wire

>>> rtl/tcprit_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcprit_cell
// One interval slot of the ring; loads its neighbor's slot when shifting.
// ---------------------------------------------------------------------------
module tcprit_cell
    import tcprit_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  shift,
    input  wire slot_t d,
    output slot_t      q
);

    logic                 used_reg;
    logic signed [SW-1:0] first_reg;
    logic signed [SW-1:0] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift)
        begin
            used_reg <= d.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            first_reg <= d.first;
            last_reg  <= d.last;
        end
    end

    assign q = '{used: used_reg, first: first_reg, last: last_reg};

endmodule
`default_nettype wire

>>> rtl/tcp_reassembly_interval_tracker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcp_reassembly_interval_tracker
// Receive-side byte range tracker: contiguous end plus a ring of
// out-of-order intervals.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result comes back
// as one word on result, marked by done for exactly one cycle, and must be
// taken then: the receiver cannot stall. The SLOTS intervals live in a ring
// of cells that rotates one slot per cycle past a single compare/merge unit.
// A segment that is old or empty answers in the cycle after acceptance. Any
// other segment takes an append probe pass and a merge pass; an exact append
// onto the recent interval is written during the merge pass and answers
// there, otherwise a decision state follows; if it must be stored a third
// pass writes it. A drain takes one pass that shifts every interval down.
// busy drops the cycle the result is registered, so the next word can be
// taken while done is high. drain_max is written through cfg_we/cfg_data;
// writes are to be made only while idle, which the block leaves to the user.
// ---------------------------------------------------------------------------
module tcp_reassembly_interval_tracker
    import tcprit_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire cmd_word_t    cmd,
    output logic              done,
    output result_word_t      result,
    input  wire logic         cfg_we,
    input  wire logic [8:0]   cfg_data
);

    localparam int KW = IDXW + 2;           // index compare width
    localparam logic [IDXW-1:0] K_LAST = IDXW'(SLOTS - 1);

    // ring of slots; head is cell 0, write-back enters at the tail
    slot_t cell_q [SLOTS];
    slot_t wb;
    logic  ring_shift;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_ring
            slot_t d_in;
            if (gi == SLOTS - 1)
            begin : g_tail
                assign d_in = wb;
            end
            else
            begin : g_mid
                assign d_in = cell_q[gi + 1];
            end
            tcprit_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ring_shift),
                .d     (d_in),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    state_t                state_reg,      state_next;
    logic [IDXW-1:0]       k_reg,          k_next;
    logic signed [CW-1:0]  contig_reg,     contig_next;
    logic [IDXW:0]         count_reg,      count_next;
    logic signed [IDXW:0]  top_reg,        top_next;
    logic signed [IDXW:0]  recent_reg,     recent_next;
    logic signed [IDXW:0]  top_new_reg,    top_new_next;
    logic [1:0]            fin_state_reg,  fin_state_next;
    logic signed [SW-1:0]  fin_pos_reg,    fin_pos_next;
    logic [8:0]            drain_max_reg,  drain_max_next;
    logic signed [VW-1:0]  cur_start_reg,  cur_start_next;
    logic signed [VW-1:0]  cur_end_reg,    cur_end_next;
    logic                  app_reg,        app_next;
    logic                  free_found_reg, free_found_next;
    logic [IDXW-1:0]       free_idx_reg,   free_idx_next;
    logic                  rec_used_reg,   rec_used_next;
    logic [8:0]            n_reg,          n_next;
    result_word_t          res_reg,        res_next;
    logic                  done_reg,       done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            contig_reg     <= '1;
            count_reg      <= '0;
            top_reg        <= '1;
            recent_reg     <= '1;
            top_new_reg    <= '1;
            fin_state_reg  <= FIN_NONE;
            fin_pos_reg    <= '0;
            drain_max_reg  <= DRAIN_MAX_RESET;
            app_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            rec_used_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            contig_reg     <= contig_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            recent_reg     <= recent_next;
            top_new_reg    <= top_new_next;
            fin_state_reg  <= fin_state_next;
            fin_pos_reg    <= fin_pos_next;
            drain_max_reg  <= drain_max_next;
            app_reg        <= app_next;
            free_found_reg <= free_found_next;
            rec_used_reg   <= rec_used_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_start_reg <= cur_start_next;
        cur_end_reg   <= cur_end_next;
        free_idx_reg  <= free_idx_next;
        n_reg         <= n_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        slot_t                head;
        logic signed [VW-1:0] seg_s;
        logic signed [VW-1:0] seg_sum;
        logic signed [VW-1:0] win_w;
        logic signed [VW-1:0] seg_e;
        logic                 cut;
        logic signed [VW-1:0] contig_w;
        logic signed [VW-1:0] dm_w;
        logic signed [VW-1:0] n_w;
        logic signed [SW-1:0] fp;
        logic signed [VW-1:0] h_first;
        logic signed [VW-1:0] h_last;
        logic signed [VW-1:0] ms;
        logic signed [VW-1:0] me;
        logic signed [KW-1:0] kk;
        logic signed [KW-1:0] top_w;
        logic signed [KW-1:0] rec_w;
        logic [IDXW:0]        cnt;

        head     = cell_q[0];
        h_first  = VW'(head.first);
        h_last   = VW'(head.last);
        kk       = $signed({2'b00, k_reg});
        top_w    = KW'(top_reg);
        rec_w    = KW'(recent_reg);
        contig_w = VW'(contig_reg);

        seg_s   = VW'(cmd.seg_offset);
        seg_sum = seg_s + $signed({7'b0, cmd.seg_len});
        win_w   = $signed({6'b0, cmd.window_room});
        cut     = seg_sum > win_w;
        seg_e   = cut ? (win_w - 18'sd1) : (seg_sum - 18'sd1);
        if (seg_e > VW'(LAST_BYTE))
        begin
            seg_e = VW'(LAST_BYTE);
        end

        dm_w = $signed({9'b0, drain_max_reg});
        n_w  = ((contig_w + 18'sd1) > dm_w) ? dm_w : (contig_w + 18'sd1);
        fp   = fin_pos_reg - SW'(n_w);

        ms  = cur_start_reg;
        me  = cur_end_reg;
        cnt = count_reg;

        state_next      = state_reg;
        k_next          = k_reg;
        contig_next     = contig_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        recent_next     = recent_reg;
        top_new_next    = top_new_reg;
        fin_state_next  = fin_state_reg;
        fin_pos_next    = fin_pos_reg;
        drain_max_next  = cfg_we ? cfg_data : drain_max_reg;
        cur_start_next  = cur_start_reg;
        cur_end_next    = cur_end_reg;
        app_next        = app_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        rec_used_next   = rec_used_reg;
        n_next          = n_reg;
        res_next        = res_reg;
        done_next       = 1'b0;
        ring_shift      = 1'b0;
        wb              = head;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    k_next = '0;
                    if (!cmd.kind)
                    begin
                        res_next.trimmed        = cut;
                        res_next.delivered      = '0;
                        res_next.fin_reached    = 1'b0;
                        res_next.contiguous_end = contig_reg[11:0];
                        if (cmd.fin_flag && (fin_state_reg != FIN_DONE))
                        begin
                            fin_state_next = FIN_PENDING;
                            fin_pos_next   = SW'(seg_e);
                        end
                        if (seg_e < contig_w)
                        begin
                            res_next.status = ST_OLD;
                            done_next       = 1'b1;
                        end
                        else if (seg_e < seg_s)
                        begin
                            res_next.status = (seg_s <= contig_w + 18'sd1) ?
                                              ST_IN_ORDER : ST_OLD;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            cur_start_next  = seg_s;
                            cur_end_next    = seg_e;
                            app_next        = 1'b0;
                            free_found_next = 1'b0;
                            state_next      = S_APPEND;
                        end
                    end
                    else
                    begin
                        n_next       = n_w[8:0];
                        contig_next  = contig_reg - CW'(n_w);
                        top_new_next = '1;
                        res_next.status         = ST_DRAINED;
                        res_next.delivered      = n_w[8:0];
                        res_next.trimmed        = 1'b0;
                        res_next.contiguous_end = 12'(contig_reg - CW'(n_w));
                        res_next.fin_reached    = 1'b0;
                        if (fin_state_reg == FIN_PENDING)
                        begin
                            fin_pos_next = fp;
                            if (fp < 0)
                            begin
                                res_next.fin_reached = 1'b1;
                                fin_state_next       = FIN_DONE;
                            end
                        end
                        state_next = S_DRAIN;
                    end
                end
            end

            // probe the recent slot for an exact append
            S_APPEND:
            begin
                ring_shift = 1'b1;
                if ((kk == rec_w) && head.used && (h_last + 18'sd1 == cur_start_reg))
                begin
                    app_next = 1'b1;
                end
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = S_MERGE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            S_MERGE:
            begin
                ring_shift = 1'b1;
                if (app_reg)
                begin
                    if (kk == rec_w)
                    begin
                        wb.last = SW'(cur_end_reg);
                    end
                end
                else
                begin
                    if ((kk <= top_w) && head.used && !(h_last + 18'sd1 < ms) &&
                        !(h_first > me + 18'sd1))
                    begin
                        if (h_last > me)
                        begin
                            me = h_last;
                        end
                        if (h_first < ms)
                        begin
                            ms = h_first;
                        end
                        wb.used    = 1'b0;
                        cnt        = count_reg - 1'b1;
                        count_next = cnt;
                        if (cnt == '0)
                        begin
                            top_next = '1;
                        end
                    end
                    cur_start_next = ms;
                    cur_end_next   = me;
                    if (!wb.used && !free_found_reg && (kk <= top_w + 1))
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = k_reg;
                    end
                end
                if (kk == rec_w)
                begin
                    rec_used_next = wb.used;
                end
                if (k_reg == K_LAST)
                begin
                    k_next = '0;
                    if (app_reg)
                    begin
                        res_next.status = ST_STORED;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            S_DECIDE:
            begin
                if ((recent_reg >= 0) && !rec_used_reg)
                begin
                    recent_next = '1;
                end
                if (cur_start_reg <= contig_w + 18'sd1)
                begin
                    contig_next             = CW'(cur_end_reg);
                    res_next.status         = ST_IN_ORDER;
                    res_next.contiguous_end = cur_end_reg[11:0];
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else if (free_found_reg)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    res_next.status = ST_FULL;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_STORE:
            begin
                ring_shift = 1'b1;
                if (k_reg == free_idx_reg)
                begin
                    wb.used  = 1'b1;
                    wb.first = SW'(cur_start_reg);
                    wb.last  = SW'(cur_end_reg);
                end
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    count_next = count_reg + 1'b1;
                    if ($signed({2'b00, free_idx_reg}) == top_w + 1)
                    begin
                        top_next = $signed({1'b0, free_idx_reg});
                    end
                    if (recent_reg < 0)
                    begin
                        recent_next = $signed({1'b0, free_idx_reg});
                    end
                    res_next.status = ST_STORED;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // shift intervals down; top falls to highest used slot
            S_DRAIN:
            begin
                ring_shift = 1'b1;
                if (head.used)
                begin
                    wb.first = head.first - SW'(n_reg);
                    wb.last  = head.last - SW'(n_reg);
                    if (kk <= top_w)
                    begin
                        top_new_next = $signed({1'b0, k_reg});
                    end
                end
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    top_next   = top_new_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire
